@@ design/psle_pkg.sv @@
package psle_pkg;

   // Largest expansion of one request: '(' + backslash + three octal digits + ')'
   localparam int MAX_CHARS = 6;
   localparam int CNT_W     = $clog2(MAX_CHARS + 1);
   localparam int IDX_W     = $clog2(MAX_CHARS);
   localparam int BODY_MAX  = 4;
   localparam int BLEN_W    = $clog2(BODY_MAX + 1);

   // Depth of the queue between classifier and serialiser
   localparam int QDEPTH    = 2;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = $clog2(QDEPTH + 1);

   // Character codes
   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_BS        = 8'h08;
   localparam logic [7:0] CH_FF        = 8'h0C;
   localparam logic [7:0] CH_LOW_N     = 8'h6E;
   localparam logic [7:0] CH_LOW_R     = 8'h72;
   localparam logic [7:0] CH_LOW_T     = 8'h74;
   localparam logic [7:0] CH_LOW_B     = 8'h62;
   localparam logic [7:0] CH_LOW_F     = 8'h66;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] PRINT_LO     = 8'd32;
   localparam logic [7:0] PRINT_HI     = 8'd126;

   // One classified request: its characters in output order
   typedef struct packed {
      logic [MAX_CHARS-1:0][7:0] chars;
      logic [CNT_W-1:0]          count;
      logic                      closing;
   } psle_desc_type;

endpackage

@@ design/pdf_string_literal_escaper.sv @@
// PDF literal-string escaper.
// Request channel (req_valid / req_stall): one string byte per request, with
// first and last marks; req_no_byte set carries no byte (first and last both
// set gives the empty string "()"). A request with no byte and no marks is
// taken and produces nothing.
// Response channel (rsp_valid / rsp_stall): one encoded character per cycle while rsp_stall is low;
// rsp_run_end marks the last character of a request, rsp_string_end the
// closing parenthesis.
// Each request expands to at most 6 characters; the serialiser sends one
// character per cycle while rsp_stall is low. A request goes through the queue,
// the current-request register and the output register before it appears.
// A two-entry queue sits between the classifier and the serialiser, so a
// new request is taken while the previous one is still being sent; req_stall
// rises only when that queue is full.
// A stalled response holds its character; the serialiser then waits and the
// queue fills. Reset empties the queue and the output register.
module pdf_string_literal_escaper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_byte,
   input  logic       req_last_byte,
   input  logic       req_no_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_run_end,
   output logic       rsp_string_end
);
   import psle_pkg::*;

   psle_desc_type push_desc, q_desc;
   logic          push, pop, q_full, q_valid;

   psle_front u_front (
      .req_valid      (req_valid),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .req_no_byte    (req_no_byte),
      .q_full         (q_full),
      .req_stall      (req_stall),
      .push           (push),
      .push_desc      (push_desc)
   );

   psle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .q_full    (q_full),
      .q_valid   (q_valid),
      .q_desc    (q_desc)
   );

   psle_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_desc         (q_desc),
      .pop            (pop),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_out_char   (rsp_out_char),
      .rsp_run_end    (rsp_run_end),
      .rsp_string_end (rsp_string_end)
   );

endmodule

@@ design/psle_front.sv @@
module psle_front (
   input  logic                    req_valid,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_first_byte,
   input  logic                    req_last_byte,
   input  logic                    req_no_byte,
   input  logic                    q_full,
   output logic                    req_stall,
   output logic                    push,
   output psle_pkg::psle_desc_type push_desc
);
   import psle_pkg::*;

   logic [BODY_MAX-1:0][7:0] body;
   logic [BLEN_W-1:0]        blen;
   logic [7:0]               esc;
   logic [CNT_W-1:0]         n;
   logic [CNT_W-1:0]         pos;

   // Escape letter for the characters that take a two-character form
   always_comb begin
      case (req_data_byte)
         CH_LPAREN:    esc = CH_LPAREN;
         CH_RPAREN:    esc = CH_RPAREN;
         CH_BACKSLASH: esc = CH_BACKSLASH;
         CH_NEWLINE:   esc = CH_LOW_N;
         CH_CR:        esc = CH_LOW_R;
         CH_TAB:       esc = CH_LOW_T;
         CH_BS:        esc = CH_LOW_B;
         CH_FF:        esc = CH_LOW_F;
         default:      esc = 8'h00;
      endcase
   end

   // Body of the request: escaped, octal or plain
   always_comb begin
      body = '0;
      blen = '0;
      if (!req_no_byte) begin
         if (esc != 8'h00) begin
            body[0] = CH_BACKSLASH;
            body[1] = esc;
            blen    = BLEN_W'(2);
         end else if (req_data_byte < PRINT_LO || req_data_byte > PRINT_HI) begin
            body[0] = CH_BACKSLASH;
            body[1] = CH_ZERO | {6'b0, req_data_byte[7:6]};
            body[2] = CH_ZERO | {5'b0, req_data_byte[5:3]};
            body[3] = CH_ZERO | {5'b0, req_data_byte[2:0]};
            blen    = BLEN_W'(4);
         end else begin
            body[0] = req_data_byte;
            blen    = BLEN_W'(1);
         end
      end
   end

   // Wrap the body in the parentheses the marks ask for
   always_comb begin
      push_desc = '0;
      n = '0;
      if (req_first_byte) begin
         push_desc.chars[0] = CH_LPAREN;
         n = CNT_W'(1);
      end
      for (int i = 0; i < BODY_MAX; i++) begin
         pos = n + CNT_W'(i);
         if (BLEN_W'(i) < blen) push_desc.chars[pos[IDX_W-1:0]] = body[i];
      end
      n = n + CNT_W'(blen);
      if (req_last_byte) begin
         push_desc.chars[n[IDX_W-1:0]] = CH_RPAREN;
         n = n + CNT_W'(1);
      end
      push_desc.count   = n;
      push_desc.closing = req_last_byte;
   end

   // Requests that expand to nothing are taken and dropped
   assign req_stall = q_full;
   assign push      = req_valid && !q_full && (push_desc.count != '0);

endmodule

@@ design/psle_queue.sv @@
module psle_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  psle_pkg::psle_desc_type push_desc,
   input  logic                    pop,
   output logic                    q_full,
   output logic                    q_valid,
   output psle_pkg::psle_desc_type q_desc
);
   import psle_pkg::*;

   psle_desc_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       cnt_ff, cnt_in;
   logic                    do_push, do_pop;

   assign q_full  = (cnt_ff == QCNT_W'(QDEPTH));
   assign q_valid = (cnt_ff != '0);
   assign q_desc  = mem_ff[rd_ptr_ff];
   assign do_push = push && !q_full;
   assign do_pop  = pop && q_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      if (!do_push && do_pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_desc;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QDEPTH))
      else $error("queue fill count above depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0 || cnt_ff == QCNT_W'(QDEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with fill count");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count missed a push");

endmodule

@@ design/psle_back.sv @@
module psle_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  psle_pkg::psle_desc_type q_desc,
   output logic                    pop,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic [7:0]              rsp_out_char,
   output logic                    rsp_run_end,
   output logic                    rsp_string_end
);
   import psle_pkg::*;

   psle_desc_type    cur_ff, cur_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             busy_ff, busy_in;
   logic             vld_ff, vld_in;
   logic [7:0]       char_ff, char_in;
   logic             rend_ff, rend_in;
   logic             send_ff, send_in;
   logic             out_free, emit, at_last;

   assign out_free = !vld_ff || !rsp_stall;
   assign emit     = busy_ff && out_free;
   assign at_last  = (CNT_W'(idx_ff) + CNT_W'(1)) == cur_ff.count;
   assign pop      = q_valid && (!busy_ff || (emit && at_last));

   // Serialise the current request into the output register
   always_comb begin
      cur_in  = cur_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      vld_in  = vld_ff && rsp_stall;
      char_in = char_ff;
      rend_in = rend_ff;
      send_in = send_ff;
      if (emit) begin
         vld_in  = 1'b1;
         char_in = cur_ff.chars[idx_ff];
         rend_in = at_last;
         send_in = at_last && cur_ff.closing;
         idx_in  = idx_ff + 1'b1;
         if (at_last) busy_in = 1'b0;
      end
      if (pop) begin
         cur_in  = q_desc;
         idx_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         vld_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      idx_ff  <= idx_in;
      char_ff <= char_in;
      rend_ff <= rend_in;
      send_ff <= send_in;
   end

   assign rsp_valid      = vld_ff;
   assign rsp_out_char   = char_ff;
   assign rsp_run_end    = rend_ff;
   assign rsp_string_end = send_ff;

   a_close_char: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && send_ff) |-> (rend_ff && char_ff == CH_RPAREN))
      else $error("closing mark on a character other than the final parenthesis");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (CNT_W'(idx_ff) < cur_ff.count))
      else $error("serialiser index past the end of the request");

   a_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |=> (cur_ff.count != '0))
      else $error("empty request reached the serialiser");

endmodule

@@ dv/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import psle_pkg::*;

   localparam int RANDOM_ITEMS   = 450;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 20;
   localparam int REPORT_LIMIT   = 10;

   // One character of the encoded literal string
   typedef struct {
      logic [7:0] ch;
      logic       run_end;
      logic       string_end;
   } enc_char_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   // Encodes each accepted request and checks the characters that come back
   class literal_scoreboard;
      enc_char_type expected_chars[$];
      enc_char_type staged[$];
      int unsigned  error_count;

      function void stage(logic [7:0] ch, logic closing);
         enc_char_type c;
         c.ch         = ch;
         c.run_end    = 1'b0;
         c.string_end = closing;
         staged.push_back(c);
      endfunction

      function void fail(string msg);
         error_count++;
         if (error_count <= REPORT_LIMIT) $display("%t: %s", $realtime, msg);
      endfunction

      function void note_request(logic [7:0] data, logic first, logic last, logic none);
         logic [7:0] esc;
         staged.delete();
         if (first) stage(CH_LPAREN, 1'b0);
         if (!none) begin
            case (data)
               CH_LPAREN:    esc = CH_LPAREN;
               CH_RPAREN:    esc = CH_RPAREN;
               CH_BACKSLASH: esc = CH_BACKSLASH;
               CH_NEWLINE:   esc = CH_LOW_N;
               CH_CR:        esc = CH_LOW_R;
               CH_TAB:       esc = CH_LOW_T;
               CH_BS:        esc = CH_LOW_B;
               CH_FF:        esc = CH_LOW_F;
               default:      esc = 8'h00;
            endcase
            if (esc != 8'h00) begin
               stage(CH_BACKSLASH, 1'b0);
               stage(esc, 1'b0);
            end else if (data < PRINT_LO || data > PRINT_HI) begin
               // three octal digits, most significant first
               stage(CH_BACKSLASH, 1'b0);
               stage(CH_ZERO + {6'd0, data[7:6]}, 1'b0);
               stage(CH_ZERO + {5'd0, data[5:3]}, 1'b0);
               stage(CH_ZERO + {5'd0, data[2:0]}, 1'b0);
            end else begin
               stage(data, 1'b0);
            end
         end
         if (last) stage(CH_RPAREN, 1'b1);
         if (staged.size() > 0) staged[staged.size() - 1].run_end = 1'b1;
         foreach (staged[i]) expected_chars.push_back(staged[i]);
      endfunction

      function void check_char(logic [7:0] ch, logic run_end, logic string_end);
         enc_char_type exp_c;
         if (expected_chars.size() == 0) begin
            fail($sformatf("unexpected character %h run_end=%b string_end=%b",
                           ch, run_end, string_end));
            return;
         end
         exp_c = expected_chars.pop_front();
         if (ch !== exp_c.ch || run_end !== exp_c.run_end ||
             string_end !== exp_c.string_end)
            fail($sformatf({"mismatch: expected char=%h run_end=%b string_end=%b,",
                            " got char=%h run_end=%b string_end=%b"},
                           exp_c.ch, exp_c.run_end, exp_c.string_end,
                           ch, run_end, string_end));
      endfunction

      function int unsigned outstanding();
         return expected_chars.size();
      endfunction

      function void check_drained();
         if (expected_chars.size() != 0)
            fail($sformatf("%0d characters never arrived", expected_chars.size()));
      endfunction
   endclass

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte  = 8'h00;
   logic       req_first_byte = 1'b0;
   logic       req_last_byte  = 1'b0;
   logic       req_no_byte    = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_run_end;
   logic       rsp_string_end;

   literal_scoreboard sb = new();

   int             idle_cycles = 0;
   int             items_sent  = 0;
   int             burst_left  = 0;
   bit             eager_phase = 1'b0;
   stall_mode_type stall_mode  = STALL_NONE;
   int             stall_mode_left = 0;
   int             stall_tick  = 0;

   pdf_string_literal_escaper dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .req_no_byte    (req_no_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_run_end    (rsp_run_end),
      .rsp_string_end (rsp_string_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver back-pressure: one of four randomly chosen stall patterns
   always @(posedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode      <= stall_mode_type'($urandom_range(0, 3));
         stall_mode_left <= $urandom_range(50, 300);
      end else begin
         stall_mode_left <= stall_mode_left - 1;
      end
      stall_tick <= stall_tick + 1;
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 99) < 30);
         STALL_PERIODIC: rsp_stall <= ((stall_tick % 7) < 3);
         default:        rsp_stall <= ($urandom_range(0, 99) < 75);
      endcase
   end

   // Handshake monitor and idle counter for the watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && !req_stall)
            sb.note_request(req_data_byte, req_first_byte, req_last_byte, req_no_byte);
         if (rsp_valid && !rsp_stall)
            sb.check_char(rsp_out_char, rsp_run_end, rsp_string_end);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // Sender: bursts of requests separated by random gaps unless eager_phase is set
   task automatic send_request(input logic [7:0] data, input logic first,
                               input logic last, input logic none);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = eager_phase ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_data_byte  <= data;
      req_first_byte <= first;
      req_last_byte  <= last;
      req_no_byte    <= none;
      do @(posedge clock); while (req_stall);
      // an empty request without marks is simply swallowed
      if (!(none && !first && !last)) items_sent++;
   endtask

   // Hold off until every expected character has come back
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      logic [7:0] specials[11];
      specials = '{CH_LPAREN, CH_RPAREN, CH_BACKSLASH, CH_NEWLINE, CH_CR, CH_TAB,
                   CH_BS, CH_FF, 8'h7F, 8'h00, 8'hFF};
      case ($urandom_range(0, 3))
         0:       return specials[$urandom_range(0, 10)];
         1:       return 8'($urandom_range(PRINT_LO, PRINT_HI));
         2:       return $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                              : 8'($urandom_range(128, 255));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_string(input int len);
      if (len == 0) begin
         send_request(8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b1);
      end else begin
         for (int i = 0; i < len; i++)
            send_request(pick_byte(), i == 0, i == len - 1, 1'b0);
      end
   endtask

   initial begin
      logic [7:0] directed_bytes[15];
      directed_bytes = '{CH_LPAREN, CH_RPAREN, CH_BACKSLASH, CH_NEWLINE, CH_CR,
                         CH_TAB, CH_BS, CH_FF, 8'd31, PRINT_LO, PRINT_HI, 8'd127,
                         8'h80, 8'h55, 8'hAA};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty string, swallowed request, extremes, lone marks
      eager_phase = 1'b1;
      send_request(8'hA5, 1'b1, 1'b1, 1'b1);
      send_request(8'h5A, 1'b0, 1'b0, 1'b1);
      send_request(8'h00, 1'b1, 1'b1, 1'b0);
      send_request(8'hFF, 1'b1, 1'b1, 1'b0);
      send_request(8'h41, 1'b0, 1'b1, 1'b0);
      send_request(8'h42, 1'b1, 1'b0, 1'b0);
      send_request(8'h00, 1'b0, 1'b1, 1'b1);
      send_request(8'hFF, 1'b1, 1'b0, 1'b1);
      // every escape class in one string
      foreach (directed_bytes[i])
         send_request(directed_bytes[i], i == 0, i == 14, 1'b0);
      wait_drain();

      // Random: mostly well-formed strings, some noise requests
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) eager_phase = ~eager_phase;
         if ($urandom_range(0, 99) < 12)
            send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         else
            send_string($urandom_range(0, 8));
         if (items_sent >= RANDOM_ITEMS / 2 && items_sent < RANDOM_ITEMS / 2 + 9)
            wait_drain();
      end

      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      sb.check_drained();
      if (sb.error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ files.f @@
design/psle_pkg.sv
design/psle_front.sv
design/psle_queue.sv
design/psle_back.sv
design/pdf_string_literal_escaper.sv
dv/tb_top.sv
